// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/slps_pkg.sv =====
package slps_pkg;

	// Input command codes.
	localparam logic [1:0] CMD_TICK     = 2'd0;
	localparam logic [1:0] CMD_LIGHTS   = 2'd1;
	localparam logic [1:0] CMD_CAN      = 2'd2;
	localparam logic [1:0] CMD_SELFTEST = 2'd3;

	// Receiver fix codes.
	localparam logic [2:0] GPS_FIX_NONE      = 3'd0;
	localparam logic [2:0] GPS_FIX_2D        = 3'd1;
	localparam logic [2:0] GPS_FIX_3D        = 3'd2;
	localparam logic [2:0] GPS_FIX_RTK_FLOAT = 3'd3;
	localparam logic [2:0] GPS_FIX_RTK_FIXED = 3'd4;

	// Configuration register indexes.
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 7;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CAN_MODE   = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DUAL_POWER = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BRIGHTNESS = 2'd2;
	localparam logic [6:0] BRIGHT_MAX = 7'd100;

	// Timing of the patterns in milliseconds.
	localparam int unsigned SELFTEST_MS   = 4000;
	localparam int unsigned SWEEP_MS      = 900;
	localparam int unsigned BOOTSEQ_MS    = 1900;
	localparam int unsigned GRACE_END_MS  = 6900;
	localparam int unsigned CYCLE_MS      = 2000;
	localparam int unsigned HALF_CYCLE_MS = 1000;
	localparam int unsigned WARN_START_MS = 1500;
	localparam int unsigned YIELD_MS      = 3000;
	localparam int unsigned CAN_SILENT_MS = 3000;
	localparam int unsigned PULSE_MS      = 500;
	localparam int unsigned FLASH_OFS_MS  = 900;
	localparam int unsigned FLASH_WRAP_MS = 1100;
	localparam int unsigned MARK_MS       = 150;

	// Breathing level and colour constants.
	localparam int unsigned LVL_BASE     = 64;
	localparam int unsigned LVL_SPAN     = 191;
	localparam logic [7:0]  COLOR_FULL   = 8'd255;
	localparam logic [7:0]  ORANGE_GREEN = 8'd110;

	// Exact constant division by reciprocal multiplication within the value ranges used.
	localparam int unsigned DIV1000_MUL   = 268436;
	localparam int          DIV1000_SHIFT = 28;
	localparam int unsigned DIV100_MUL    = 10486;
	localparam int          DIV100_SHIFT  = 20;

	// The remainder unit consumes this many bits of the time value per cycle.
	localparam int MOD_DIGIT = 4;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] now_ms;
		logic        gps_heard;
		logic [2:0]  gps_fix_state;
		logic        compass_ok;
	} item_t;

	typedef struct packed {
		logic       led_drive;
		logic [7:0] led_red;
		logic [7:0] led_green;
		logic [7:0] led_blue;
	} result_t;

	typedef struct packed {
		logic       can_mode;
		logic       dual_power;
		logic [6:0] brightness_pct;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_LIGHTS,
		KIND_CAN,
		KIND_SELFTEST
	} kind_t;

	typedef enum logic [2:0] {
		FIX_NONE,
		FIX_2D,
		FIX_3D,
		FIX_RTK_FLOAT,
		FIX_RTK_FIXED,
		FIX_OTHER
	} fix_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] now_ms;
		logic        gps_heard;
		fix_t        fix;
		logic        compass_ok;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== rtl/core/slps_front.sv =====
module slps_front (
	input  logic            clk,
	input  logic            arst_n,
	input  slps_pkg::item_t item,
	input  logic            item_valid,
	output logic            item_ready,
	output slps_pkg::entry_t push_entry,
	output logic            push_valid,
	input  logic            push_ready
);

	logic             valid_s1;
	slps_pkg::entry_t entry_s1;
	slps_pkg::entry_t entry_n;

	always_comb begin
		entry_n.now_ms     = item.now_ms;
		entry_n.gps_heard  = item.gps_heard;
		entry_n.compass_ok = item.compass_ok;
		unique case (item.cmd)
			slps_pkg::CMD_TICK:     entry_n.kind = slps_pkg::KIND_TICK;
			slps_pkg::CMD_LIGHTS:   entry_n.kind = slps_pkg::KIND_LIGHTS;
			slps_pkg::CMD_CAN:      entry_n.kind = slps_pkg::KIND_CAN;
			slps_pkg::CMD_SELFTEST: entry_n.kind = slps_pkg::KIND_SELFTEST;
			default:                entry_n.kind = slps_pkg::KIND_TICK;
		endcase
		unique case (item.gps_fix_state)
			slps_pkg::GPS_FIX_NONE:      entry_n.fix = slps_pkg::FIX_NONE;
			slps_pkg::GPS_FIX_2D:        entry_n.fix = slps_pkg::FIX_2D;
			slps_pkg::GPS_FIX_3D:        entry_n.fix = slps_pkg::FIX_3D;
			slps_pkg::GPS_FIX_RTK_FLOAT: entry_n.fix = slps_pkg::FIX_RTK_FLOAT;
			slps_pkg::GPS_FIX_RTK_FIXED: entry_n.fix = slps_pkg::FIX_RTK_FIXED;
			default:                     entry_n.fix = slps_pkg::FIX_OTHER;
		endcase
	end

	assign item_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			entry_s1 <= entry_n;
		end
	end

endmodule

// ===== rtl/core/slps_queue.sv =====
module slps_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  slps_pkg::entry_t        push_entry,
	input  logic                    push_valid,
	output logic                    push_ready,
	output slps_pkg::entry_t        head,
	input  logic                    pop,
	output slps_pkg::queue_status_t status
);

	localparam int PTR_W = (slps_pkg::QUEUE_DEPTH > 1) ? $clog2(slps_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(slps_pkg::QUEUE_DEPTH + 1);

	slps_pkg::entry_t mem [slps_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(slps_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign push_ready   = !status.full;
	assign do_push      = push_valid && push_ready;
	assign do_pop       = pop && !status.empty;
	assign head         = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(slps_pkg::QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(slps_pkg::QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/slps_back.sv =====
module slps_back #(
	parameter int TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slps_pkg::cfg_t    cfg,
	input  logic              q_valid,
	input  slps_pkg::entry_t  q_head,
	output logic              q_pop,
	output logic              result_valid,
	input  logic              result_ready,
	output slps_pkg::result_t result
);

	localparam int MOD_STEPS = (TIME_BITS + slps_pkg::MOD_DIGIT - 1) / slps_pkg::MOD_DIGIT;
	localparam int MOD_W     = MOD_STEPS * slps_pkg::MOD_DIGIT;
	localparam int CNT_W     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MOD,
		ST_LVL,
		ST_LVL2,
		ST_PICK,
		ST_MULP,
		ST_DIVP,
		ST_DONE
	} state_t;

	state_t             state_q;
	slps_pkg::entry_t   item_q;
	logic [TIME_BITS-1:0] boot_q;
	logic [TIME_BITS-1:0] test_end_q;
	logic [TIME_BITS-1:0] lights_q;
	logic [TIME_BITS-1:0] can_q;
	logic [TIME_BITS-1:0] since_q;
	logic               test_q;
	logic [MOD_W-1:0]   mod_sr_q;
	logic [10:0]        rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [17:0]        prod_q;
	logic [7:0]         lvl_q;
	logic [7:0]         col_q [3];
	logic [7:0]         sc_q [3];
	logic [1:0]         ch_q;
	logic [14:0]        sp_q;
	logic               drive_q;
	logic               result_valid_q;
	slps_pkg::result_t  result_q;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] test_t;
	logic [TIME_BITS-1:0] anchor;
	logic [TIME_BITS-1:0] since_n;
	logic               test_on;
	logic               yield;
	logic               can_silent;
	logic [11:0]        mod_r;
	logic [10:0]        rem_n;
	logic [9:0]         up;
	logic [36:0]        lvl_prod;
	logic [28:0]        sc_prod;
	logic [6:0]         pct_eff;
	logic [9:0]         pulse_x;
	logic [9:0]         pulse_m;
	logic [10:0]        flash_c;
	logic               flash_on;
	logic [8:0]         warn_t;
	logic               warn_hit;
	logic               pk_drive;
	logic [7:0]         pk_r;
	logic [7:0]         pk_g;
	logic [7:0]         pk_b;
	logic               out_free;

	assign now_t      = TIME_BITS'(item_q.now_ms);
	assign test_on    = (test_end_q != '0) && (now_t < test_end_q);
	assign test_t     = now_t - test_end_q + TIME_BITS'(slps_pkg::SELFTEST_MS);
	assign yield      = cfg.can_mode && (lights_q != '0) &&
		((now_t - lights_q) < TIME_BITS'(slps_pkg::YIELD_MS));
	assign anchor     = (boot_q == '0) ? now_t : boot_q;
	assign since_n    = now_t - anchor;
	assign can_silent = (can_q == '0) ||
		((now_t - can_q) > TIME_BITS'(slps_pkg::CAN_SILENT_MS));
	assign pct_eff    = (cfg.brightness_pct > slps_pkg::BRIGHT_MAX) ? slps_pkg::BRIGHT_MAX :
		cfg.brightness_pct;
	assign out_free   = !result_valid_q || result_ready;
	assign q_pop      = (state_q == ST_IDLE) && q_valid;

	// Remainder by the cycle length, one restoring step per incoming bit.
	always_comb begin
		mod_r = {1'b0, rem_q};
		for (int i = 0; i < slps_pkg::MOD_DIGIT; i++) begin
			mod_r = {mod_r[10:0], mod_sr_q[MOD_W-1-i]};
			if (mod_r >= 12'(slps_pkg::CYCLE_MS)) begin
				mod_r = mod_r - 12'(slps_pkg::CYCLE_MS);
			end
		end
		rem_n = mod_r[10:0];
	end

	assign up = (rem_q < 11'(slps_pkg::HALF_CYCLE_MS)) ? rem_q[9:0] :
		10'(11'(slps_pkg::CYCLE_MS) - rem_q);
	assign lvl_prod = 37'(prod_q) * 37'(slps_pkg::DIV1000_MUL);
	assign sc_prod  = 29'(sp_q) * 29'(slps_pkg::DIV100_MUL);

	// Pattern selection once the position in the cycle is known.
	always_comb begin
		pulse_x  = since_q[9:0] - 10'(slps_pkg::SWEEP_MS);
		pulse_m  = (pulse_x >= 10'(slps_pkg::PULSE_MS)) ? pulse_x - 10'(slps_pkg::PULSE_MS) :
			pulse_x;
		flash_c  = (rem_q >= 11'(slps_pkg::FLASH_OFS_MS)) ?
			rem_q - 11'(slps_pkg::FLASH_OFS_MS) : rem_q + 11'(slps_pkg::FLASH_WRAP_MS);
		flash_on = (flash_c < 11'd120) || (flash_c >= 11'd200 && flash_c < 11'd320) ||
			(flash_c >= 11'd400 && flash_c < 11'd520);
		warn_t   = 9'(rem_q - 11'(slps_pkg::WARN_START_MS));
		warn_hit = cfg.dual_power || (cfg.can_mode && !item_q.compass_ok) ||
			(cfg.can_mode && can_silent);
		pk_drive = 1'b1;
		pk_r     = '0;
		pk_g     = '0;
		pk_b     = '0;
		priority if (test_q) begin
			if (rem_q < 11'd500) begin
				pk_r = slps_pkg::COLOR_FULL;
			end else if (rem_q < 11'd1000) begin
				pk_g = slps_pkg::COLOR_FULL;
			end else if (rem_q < 11'd1500) begin
				pk_b = slps_pkg::COLOR_FULL;
			end else begin
				pk_r = slps_pkg::COLOR_FULL;
				pk_g = slps_pkg::COLOR_FULL;
				pk_b = slps_pkg::COLOR_FULL;
			end
		end else if (since_q < TIME_BITS'(slps_pkg::BOOTSEQ_MS)) begin
			if (since_q < TIME_BITS'(300)) begin
				pk_r = slps_pkg::COLOR_FULL;
			end else if (since_q < TIME_BITS'(600)) begin
				pk_g = slps_pkg::COLOR_FULL;
			end else if (since_q < TIME_BITS'(slps_pkg::SWEEP_MS)) begin
				pk_b = slps_pkg::COLOR_FULL;
			end else begin
				// Mode pulses: magenta for CAN, cyan for the direct link.
				pk_r = (cfg.can_mode && pulse_m < 10'd300) ? slps_pkg::COLOR_FULL : '0;
				pk_g = (!cfg.can_mode && pulse_m < 10'd300) ? slps_pkg::COLOR_FULL : '0;
				pk_b = (pulse_m < 10'd300) ? slps_pkg::COLOR_FULL : '0;
			end
		end else if (!item_q.gps_heard) begin
			if (since_q < TIME_BITS'(slps_pkg::GRACE_END_MS)) begin
				pk_r = {1'b0, lvl_q[7:1]};
				pk_g = {1'b0, lvl_q[7:1]};
				pk_b = {1'b0, lvl_q[7:1]};
			end else if (flash_on) begin
				pk_r = slps_pkg::COLOR_FULL;
			end
		end else if (rem_q >= 11'(slps_pkg::WARN_START_MS) && warn_hit) begin
			priority if (cfg.dual_power) begin
				if (warn_t < 9'd100 || (warn_t >= 9'd200 && warn_t < 9'd300)) begin
					pk_r = slps_pkg::COLOR_FULL;
					pk_g = slps_pkg::ORANGE_GREEN;
				end
			end else if (!item_q.compass_ok) begin
				pk_r = (warn_t < 9'd250) ? slps_pkg::COLOR_FULL : '0;
			end else begin
				pk_r = (warn_t < 9'd250) ? slps_pkg::COLOR_FULL : '0;
				pk_b = (warn_t < 9'd250) ? slps_pkg::COLOR_FULL : '0;
			end
		end else begin
			unique case (item_q.fix)
				slps_pkg::FIX_NONE: pk_b = lvl_q;
				slps_pkg::FIX_2D:   pk_g = lvl_q;
				slps_pkg::FIX_3D:   pk_g = slps_pkg::COLOR_FULL;
				slps_pkg::FIX_RTK_FLOAT: begin
					if (rem_q < 11'(slps_pkg::MARK_MS)) begin
						pk_b = slps_pkg::COLOR_FULL;
					end else begin
						pk_g = slps_pkg::COLOR_FULL;
					end
				end
				slps_pkg::FIX_RTK_FIXED: begin
					pk_g = slps_pkg::COLOR_FULL;
					if (rem_q < 11'(slps_pkg::MARK_MS)) begin
						pk_r = slps_pkg::COLOR_FULL;
						pk_b = slps_pkg::COLOR_FULL;
					end
				end
				default: pk_drive = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			item_q         <= '0;
			boot_q         <= '0;
			test_end_q     <= '0;
			lights_q       <= '0;
			can_q          <= '0;
			since_q        <= '0;
			test_q         <= 1'b0;
			mod_sr_q       <= '0;
			rem_q          <= '0;
			cnt_q          <= '0;
			prod_q         <= '0;
			lvl_q          <= '0;
			col_q          <= '{default: '0};
			sc_q           <= '{default: '0};
			ch_q           <= '0;
			sp_q           <= '0;
			drive_q        <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q  <= q_head;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					drive_q <= 1'b0;
					rem_q   <= '0;
					cnt_q   <= '0;
					unique case (item_q.kind)
						slps_pkg::KIND_LIGHTS: begin
							lights_q <= now_t;
							state_q  <= ST_DONE;
						end
						slps_pkg::KIND_CAN: begin
							can_q   <= now_t;
							state_q <= ST_DONE;
						end
						slps_pkg::KIND_SELFTEST: begin
							test_end_q <= now_t + TIME_BITS'(slps_pkg::SELFTEST_MS);
							state_q    <= ST_DONE;
						end
						slps_pkg::KIND_TICK: begin
							if (test_on) begin
								test_q   <= 1'b1;
								mod_sr_q <= MOD_W'(test_t);
								state_q  <= ST_MOD;
							end else begin
								// An expired self-test is dropped before anything else.
								test_end_q <= '0;
								if (yield) begin
									state_q <= ST_DONE;
								end else begin
									boot_q   <= anchor;
									since_q  <= since_n;
									test_q   <= 1'b0;
									mod_sr_q <= MOD_W'(since_n);
									state_q  <= ST_MOD;
								end
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_MOD: begin
					rem_q    <= rem_n;
					mod_sr_q <= mod_sr_q << slps_pkg::MOD_DIGIT;
					cnt_q    <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
						state_q <= ST_LVL;
					end
				end
				ST_LVL: begin
					prod_q  <= 18'(up) * 18'(slps_pkg::LVL_SPAN);
					state_q <= ST_LVL2;
				end
				ST_LVL2: begin
					lvl_q   <= 8'(lvl_prod[36:slps_pkg::DIV1000_SHIFT]) + 8'(slps_pkg::LVL_BASE);
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					drive_q  <= pk_drive;
					col_q[0] <= pk_r;
					col_q[1] <= pk_g;
					col_q[2] <= pk_b;
					ch_q     <= '0;
					state_q  <= pk_drive ? ST_MULP : ST_DONE;
				end
				ST_MULP: begin
					sp_q    <= 15'(col_q[ch_q]) * 15'(pct_eff);
					state_q <= ST_DIVP;
				end
				ST_DIVP: begin
					sc_q[ch_q] <= sc_prod[slps_pkg::DIV100_SHIFT+7:slps_pkg::DIV100_SHIFT];
					ch_q       <= ch_q + 2'd1;
					state_q    <= (ch_q == 2'd2) ? ST_DONE : ST_MULP;
				end
				ST_DONE: begin
					if (out_free) begin
						result_q.led_drive <= drive_q;
						result_q.led_red   <= drive_q ? sc_q[0] : '0;
						result_q.led_green <= drive_q ? sc_q[1] : '0;
						result_q.led_blue  <= drive_q ? sc_q[2] : '0;
						result_valid_q     <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/core/status_led_pattern_sequencer_unit.sv =====
// Status LED pattern sequencer.
// Input channel item/item_valid/item_ready takes ticks and events; every
// accepted item yields exactly one transfer on result/result_valid/result_ready,
// in order. Events (lights command, CAN frame, self-test start) update the
// stored timestamps and return a no-drive result; ticks return a colour or none.
// The write port cfg_we/cfg_index/cfg_wdata sets CAN mode, the dual power
// warning and the brightness percent; write it only while no item is pending.
// An input register feeds a two-entry queue, so the front keeps taking items
// while the back end works or the output is stalled, until the queue fills.
// The back end handles one item at a time. An event only passes its evaluate
// and done states; a tick that does not yield also runs the remainder unit,
// which eats four time bits per cycle, the level steps and, when it drives,
// three channel scaling passes through one multiplier. An accepted item
// passes the input register and the queue before the back end takes it.
// When the receiver stalls, the finished result waits in the output register
// and the back end holds its next result until that one is taken.
// Reset clears all timestamps (no boot anchor, no self-test, nothing seen),
// sets brightness to 100 percent and empties the queue.
`include "assert_macros.svh"

module status_led_pattern_sequencer_unit #(
	parameter int TIME_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  slps_pkg::item_t                       item,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	output slps_pkg::result_t                     result,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	input  logic                                  cfg_we,
	input  logic [slps_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [slps_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);

	slps_pkg::cfg_t          cfg_q;
	slps_pkg::entry_t        push_entry;
	logic                    push_valid;
	logic                    push_ready;
	slps_pkg::entry_t        q_head;
	logic                    q_pop;
	slps_pkg::queue_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.can_mode       <= 1'b0;
			cfg_q.dual_power     <= 1'b0;
			cfg_q.brightness_pct <= slps_pkg::BRIGHT_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slps_pkg::REG_CAN_MODE:   cfg_q.can_mode <= cfg_wdata[0];
				slps_pkg::REG_DUAL_POWER: cfg_q.dual_power <= cfg_wdata[0];
				slps_pkg::REG_BRIGHTNESS: cfg_q.brightness_pct <= cfg_wdata;
				default: ;
			endcase
		end
	end

	slps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	slps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.head       (q_head),
		.pop        (q_pop),
		.status     (q_status)
	);

	slps_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (!q_status.empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`ASSERT_RST(a_nodrive_dark, clk, arst_n, result_valid && !result.led_drive |-> (result.led_red == 8'd0 && result.led_green == 8'd0 && result.led_blue == 8'd0), "no-drive result carries a colour")
	`ASSERT_RST(a_zero_bright_dark, clk, arst_n, result_valid && cfg_q.brightness_pct == 7'd0 |-> (result.led_red == 8'd0 && result.led_green == 8'd0 && result.led_blue == 8'd0), "colour shown at zero brightness")
	`ASSERT_ALWAYS(a_pop_nonempty, clk, q_pop |-> !q_status.empty, "queue popped while empty")
	`ASSERT_RST(a_push_room, clk, arst_n, push_valid && q_status.full |-> !push_ready, "queue accepts a push while full")

endmodule

// ===== verif/tb_status_led_pattern_sequencer_unit.sv =====
`timescale 1ns / 100ps

module tb_status_led_pattern_sequencer_unit;
	import slps_pkg::*;

	localparam int CYCLE_LIMIT     = 500000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int ITEMS_PER_PHASE = 115;

	class led_scoreboard;
		bit              can_mode = 1'b0;
		bit              dual_power = 1'b0;
		bit [6:0]        bright = 7'd100;
		bit [31:0]       boot_anchor = '0;
		bit [31:0]       selftest_end = '0;
		bit [31:0]       lights_seen = '0;
		bit [31:0]       can_seen = '0;
		result_t         expected_leds[$];
		int              errors = 0;

		function void set_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] val);
			case (idx)
				REG_CAN_MODE:   can_mode = val[0];
				REG_DUAL_POWER: dual_power = val[0];
				REG_BRIGHTNESS: bright = val;
				default: ;
			endcase
		endfunction

		function result_t drive_rgb(input int unsigned r, input int unsigned g,
			input int unsigned b);
			result_t res;
			int unsigned pct;
			pct = (bright > BRIGHT_MAX) ? 100 : bright;
			res.led_drive = 1'b1;
			res.led_red   = 8'(((r & 255) * pct) / 100);
			res.led_green = 8'(((g & 255) * pct) / 100);
			res.led_blue  = 8'(((b & 255) * pct) / 100);
			return res;
		endfunction

		function result_t drive_dim(input int unsigned r, input int unsigned g,
			input int unsigned b, input int unsigned lvl);
			return drive_rgb(r * lvl / 255, g * lvl / 255, b * lvl / 255);
		endfunction

		// Only one warning is drawn per cycle tail; dual power outranks the CAN checks.
		function bit warning_color(input bit [31:0] t, input bit [31:0] now,
			input bit compass, output result_t res);
			bit on;
			int unsigned v;
			res = '0;
			if (dual_power) begin
				on = (t < 100) || (t >= 200 && t < 300);
				res = drive_rgb(on ? 255 : 0, on ? ORANGE_GREEN : 0, 0);
				return 1'b1;
			end
			if (can_mode && !compass) begin
				res = drive_rgb(t < 250 ? 255 : 0, 0, 0);
				return 1'b1;
			end
			if (can_mode && (can_seen == 0 || now - can_seen > CAN_SILENT_MS)) begin
				v = (t < 250) ? 255 : 0;
				res = drive_rgb(v, 0, v);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function result_t led_for_item(input item_t it);
			bit [31:0]   now;
			bit [31:0]   t;
			bit [31:0]   since;
			bit [31:0]   cyc;
			bit [31:0]   up;
			bit [31:0]   c;
			int unsigned lvl;
			int unsigned v;
			result_t     res;
			now = it.now_ms;
			res = '0;
			case (it.cmd)
				CMD_LIGHTS: begin
					lights_seen = now;
					return res;
				end
				CMD_CAN: begin
					can_seen = now;
					return res;
				end
				CMD_SELFTEST: begin
					selftest_end = now + SELFTEST_MS;
					return res;
				end
				default: ;
			endcase

			if (selftest_end != 0) begin
				if (now < selftest_end) begin
					t = now - (selftest_end - SELFTEST_MS);
					case ((t / PULSE_MS) % 4)
						0: return drive_rgb(255, 0, 0);
						1: return drive_rgb(0, 255, 0);
						2: return drive_rgb(0, 0, 255);
						default: return drive_rgb(255, 255, 255);
					endcase
				end
				selftest_end = '0;
			end

			if (can_mode && lights_seen != 0 && now - lights_seen < YIELD_MS)
				return res;

			// A zero anchor means not anchored, so an anchor taken at time zero repeats.
			if (boot_anchor == 0)
				boot_anchor = now;
			since = now - boot_anchor;

			if (since < BOOTSEQ_MS) begin
				if (since < 300)
					return drive_rgb(255, 0, 0);
				if (since < 600)
					return drive_rgb(0, 255, 0);
				if (since < SWEEP_MS)
					return drive_rgb(0, 0, 255);
				v = (((since - SWEEP_MS) % PULSE_MS) < 300) ? 255 : 0;
				return can_mode ? drive_rgb(v, 0, v) : drive_rgb(0, v, v);
			end

			cyc = since % CYCLE_MS;
			up = (cyc < HALF_CYCLE_MS) ? cyc : CYCLE_MS - cyc;
			lvl = LVL_BASE + (up * LVL_SPAN) / HALF_CYCLE_MS;

			if (!it.gps_heard) begin
				if (since < GRACE_END_MS)
					return drive_dim(255, 255, 255, lvl / 2);
				c = (since - GRACE_END_MS) % CYCLE_MS;
				if (c < 600 && (c % 200) < 120)
					return drive_rgb(255, 0, 0);
				return drive_rgb(0, 0, 0);
			end

			if (cyc >= WARN_START_MS &&
				warning_color(cyc - WARN_START_MS, now, it.compass_ok, res))
				return res;

			case (it.gps_fix_state)
				GPS_FIX_NONE:      return drive_dim(0, 0, 255, lvl);
				GPS_FIX_2D:        return drive_dim(0, 255, 0, lvl);
				GPS_FIX_3D:        return drive_rgb(0, 255, 0);
				GPS_FIX_RTK_FLOAT: return (cyc < MARK_MS) ? drive_rgb(0, 0, 255) :
					drive_rgb(0, 255, 0);
				GPS_FIX_RTK_FIXED: return (cyc < MARK_MS) ? drive_rgb(255, 255, 255) :
					drive_rgb(0, 255, 0);
				default: return '0;
			endcase
		endfunction

		function void note_item(input item_t it);
			expected_leds.push_back(led_for_item(it));
		endfunction

		function void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (expected_leds.size() == 0) begin
				$error("result transfer with nothing pending: %h", got);
				errors++;
				return;
			end
			want = expected_leds.pop_front();
			compare_field("led_drive", 8'(want.led_drive), 8'(got.led_drive));
			compare_field("led_red", want.led_red, got.led_red);
			compare_field("led_green", want.led_green, got.led_green);
			compare_field("led_blue", want.led_blue, got.led_blue);
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	item_t                      item = '0;
	logic                       item_valid = 1'b0;
	logic                       item_ready;
	result_t                    result;
	logic                       result_valid;
	logic                       result_ready = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

	led_scoreboard led_checker = new;
	bit [31:0]     clock_ms = '0;
	int            burst_left = 0;
	int            ready_mode = 0;
	int            ready_left = 0;
	int            cycle_count = 0;

	status_led_pattern_sequencer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver switches between always ready, coin toss, periodic and long stalls.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_left <= $urandom_range(50, 400);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0: result_ready <= 1'b1;
			1: result_ready <= 1'($urandom_range(0, 1));
			2: result_ready <= (ready_left % 8 == 0);
			default: result_ready <= ($urandom_range(0, 39) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			led_checker.check_result(result);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_status_led_pattern_sequencer_unit: errors");
		$finish;
	end

	// Valid drops at the end of a burst when a gap is drawn; within a burst only a drain wait drops it.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic offer_item(input item_t it);
		pace_sender();
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		led_checker.note_item(it);
	endtask

	task automatic offer(input logic [1:0] cmd, input logic [31:0] now,
		input logic heard, input logic [2:0] fix, input logic compass);
		item_t it;
		it.cmd = cmd;
		it.now_ms = now;
		it.gps_heard = heard;
		it.gps_fix_state = fix;
		it.compass_ok = compass;
		offer_item(it);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (led_checker.expected_leds.size() != 0)
			@(posedge clk);
	endtask

	task automatic change_settings(input logic can, input logic dual,
		input logic [6:0] bright);
		logic [CFG_INDEX_WIDTH-1:0] regs[3];
		logic [CFG_DATA_WIDTH-1:0]  vals[3];
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		regs = '{REG_CAN_MODE, REG_DUAL_POWER, REG_BRIGHTNESS};
		vals = '{7'(can), 7'(dual), bright};
		for (int k = 0; k < 3; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[k];
			cfg_wdata <= vals[k];
			@(posedge clk);
			led_checker.set_reg(regs[k], vals[k]);
		end
		cfg_we <= 1'b0;
	endtask

	// Time mostly moves forward in small steps; jumps back near the boot anchor
	// reopen the sweep and grace windows, and wild jumps cover the whole range.
	task automatic run_phase(input int n, input int heard_pct);
		item_t it;
		int    r;
		int    drain_at;
		drain_at = $urandom_range(0, n - 1);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				clock_ms += $urandom_range(1, 60);
			else if (r < 80)
				clock_ms += $urandom_range(200, 2500);
			else if (r < 88 && led_checker.boot_anchor != 0)
				clock_ms = led_checker.boot_anchor + $urandom_range(0, 8000);
			else if (r < 92)
				clock_ms = $urandom;
			else if (r < 95)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 6000);
			else if (r == 99)
				clock_ms = '0;
			r = $urandom_range(0, 199);
			if (r < 4)
				it.cmd = CMD_LIGHTS;
			else if (r < 20)
				it.cmd = CMD_CAN;
			else if (r < 23)
				it.cmd = CMD_SELFTEST;
			else
				it.cmd = CMD_TICK;
			it.now_ms = clock_ms;
			it.gps_heard = ($urandom_range(0, 99) < heard_pct);
			it.gps_fix_state = 3'($urandom_range(0, 7));
			it.compass_ok = ($urandom_range(0, 4) != 0);
			offer_item(it);
			if (i == drain_at)
				wait_drained();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Boot anchor taken at time zero is taken again on the next tick.
		offer(CMD_TICK, 32'd0, 1'b1, GPS_FIX_NONE, 1'b1);
		// Zero timestamps read as never seen.
		offer(CMD_LIGHTS, 32'd0, 1'b1, GPS_FIX_NONE, 1'b1);
		offer(CMD_CAN, 32'd0, 1'b1, GPS_FIX_NONE, 1'b1);
		offer(CMD_TICK, 32'd1000, 1'b1, GPS_FIX_NONE, 1'b1);
		offer(CMD_TICK, 32'd1300, 1'b1, GPS_FIX_NONE, 1'b1);
		offer(CMD_TICK, 32'd1600, 1'b1, GPS_FIX_NONE, 1'b1);
		offer(CMD_TICK, 32'd1900, 1'b1, GPS_FIX_NONE, 1'b1);
		offer(CMD_TICK, 32'd2250, 1'b1, GPS_FIX_NONE, 1'b1);
		// A self-test whose end wraps to zero never runs.
		offer(CMD_SELFTEST, 32'hFFFF_F060, 1'b1, GPS_FIX_NONE, 1'b1);
		offer(CMD_TICK, 32'd2400, 1'b1, GPS_FIX_NONE, 1'b1);
		offer(CMD_SELFTEST, 32'd10000, 1'b1, GPS_FIX_2D, 1'b1);
		offer(CMD_TICK, 32'd10000, 1'b1, GPS_FIX_2D, 1'b1);
		offer(CMD_TICK, 32'd11100, 1'b1, GPS_FIX_2D, 1'b1);
		offer(CMD_TICK, 32'd11600, 1'b1, GPS_FIX_2D, 1'b1);
		offer(CMD_TICK, 32'd13999, 1'b1, GPS_FIX_2D, 1'b1);
		offer(CMD_TICK, 32'd14000, 1'b1, GPS_FIX_2D, 1'b1);
		// No receiver yet: dim breathing in the grace period, then the red flash.
		offer(CMD_TICK, 32'd4000, 1'b0, GPS_FIX_NONE, 1'b1);
		offer(CMD_TICK, 32'd7950, 1'b0, GPS_FIX_NONE, 1'b1);
		offer(CMD_TICK, 32'd8080, 1'b0, GPS_FIX_NONE, 1'b1);
		// Fix codes above range drive nothing.
		offer(CMD_TICK, 32'd20000, 1'b1, 3'd5, 1'b1);
		offer(CMD_TICK, 32'd20010, 1'b1, 3'd6, 1'b1);
		offer(CMD_TICK, 32'd20020, 1'b1, 3'd7, 1'b1);
		offer(CMD_TICK, 32'd21000, 1'b1, GPS_FIX_RTK_FLOAT, 1'b1);
		// With CAN mode off, a bad compass raises no warning.
		offer(CMD_TICK, 32'd22600, 1'b1, GPS_FIX_3D, 1'b0);
		offer(CMD_TICK, 32'hFFFF_FFFF, 1'b1, GPS_FIX_RTK_FIXED, 1'b1);
		clock_ms = 32'hFFFF_FFFF;

		run_phase(ITEMS_PER_PHASE, 85);
		change_settings(1'b1, 1'b0, 7'd100);
		run_phase(ITEMS_PER_PHASE, 85);
		change_settings(1'b1, 1'b1, 7'd37);
		run_phase(ITEMS_PER_PHASE, 85);
		change_settings(1'b0, 1'b1, 7'd0);
		run_phase(ITEMS_PER_PHASE, 50);
		change_settings(1'b1, 1'b0, 7'd127);
		run_phase(ITEMS_PER_PHASE, 90);
		change_settings(1'b0, 1'b0, 7'd101);
		run_phase(ITEMS_PER_PHASE, 20);
		change_settings(1'b1, 1'b0, 7'd1);
		run_phase(ITEMS_PER_PHASE, 90);
		change_settings(1'b0, 1'b0, 7'd100);
		run_phase(ITEMS_PER_PHASE, 90);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (led_checker.errors == 0)
			$display("tb_status_led_pattern_sequencer_unit: clean");
		else
			$display("tb_status_led_pattern_sequencer_unit: errors");
		$finish;
	end

endmodule
